// ===== hw/rtl/gcma_pkg.sv =====
// shared types, constants and microcode table for the motion accel block
`timescale 1ns / 1ps

package gcma_pkg;

    // field widths
    localparam int QW    = 16;
    localparam int AW    = 19;
    localparam int DTW   = 16;
    localparam int TAUW  = 20;
    localparam int GW    = 15;
    localparam int CFGIW = 2;

    // datapath widths
    localparam int RW    = 34;
    localparam int OPAW  = 34;
    localparam int OPBW  = 22;
    localparam int MULW  = OPAW + OPBW;
    localparam int ACCW  = 58;
    localparam int PRODW = 32;
    localparam int RESW  = 22;
    localparam int NUMW  = 42;
    localparam int MAGW  = 41;
    localparam int DENW  = TAUW + 1;
    localparam int DCW   = 6;
    localparam int STEPW = 6;
    localparam int FRAC  = 28;

    localparam logic [TAUW-1:0] TAU_RESET = 20'd8500;
    localparam logic [GW-1:0]   G_RESET   = 15'd10037;

    localparam logic signed [AW-1:0] OUT_MAX = 19'sh3FFFF;
    localparam logic signed [AW-1:0] OUT_MIN = 19'sh40000;

    localparam logic signed [RW-1:0]   HALF_R   = RW'(64'sd134217728);
    localparam logic signed [MULW-1:0] HALF_MUL = MULW'(64'sd134217728);
    localparam logic signed [ACCW-1:0] HALF_ACC = ACCW'(64'sd134217728);

    typedef enum logic [CFGIW-1:0] {
        CFG_TAU  = 2'd0,
        CFG_GRAV = 2'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MS_NONE,
        MS_QQ,
        MS_RG,
        MS_RESDT,
        MS_FTAU,
        MS_RF
    } msel_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_PROD,
        ACT_GRAV,
        ACT_SET,
        ACT_ADD,
        ACT_EARTH
    } act_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV
    } state_t;

    typedef struct packed {
        msel_t      msel;
        act_t       act;
        logic [3:0] idx;
        logic       div;
        logic       last;
    } ucode_t;

    typedef struct packed {
        logic       load;
        msel_t      msel;
        act_t       act;
        logic [3:0] idx;
        logic       div_start;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

    function automatic ucode_t mk(msel_t m, act_t a, logic [3:0] i, logic d, logic l);
        ucode_t u;
        u.msel = m;
        u.act  = a;
        u.idx  = i;
        u.div  = d;
        u.last = l;
        return u;
    endfunction

    // one entry per step: multiply issue plus the action on its registered product
    function automatic ucode_t ucode(logic [STEPW-1:0] step);
        ucode_t u;
        u = mk(MS_NONE, ACT_NONE, 4'd0, 1'b0, 1'b0);
        case (step)
            6'd0:  u = mk(MS_QQ, ACT_PROD, 4'd0, 1'b0, 1'b0);
            6'd1:  u = mk(MS_QQ, ACT_PROD, 4'd1, 1'b0, 1'b0);
            6'd2:  u = mk(MS_QQ, ACT_PROD, 4'd2, 1'b0, 1'b0);
            6'd3:  u = mk(MS_QQ, ACT_PROD, 4'd3, 1'b0, 1'b0);
            6'd4:  u = mk(MS_QQ, ACT_PROD, 4'd4, 1'b0, 1'b0);
            6'd5:  u = mk(MS_QQ, ACT_PROD, 4'd5, 1'b0, 1'b0);
            6'd6:  u = mk(MS_QQ, ACT_PROD, 4'd6, 1'b0, 1'b0);
            6'd7:  u = mk(MS_QQ, ACT_PROD, 4'd7, 1'b0, 1'b0);
            6'd8:  u = mk(MS_QQ, ACT_PROD, 4'd8, 1'b0, 1'b0);
            // axis x
            6'd10: u = mk(MS_RG,    ACT_GRAV, 4'd0, 1'b0, 1'b0);
            6'd12: u = mk(MS_RESDT, ACT_SET,  4'd0, 1'b0, 1'b0);
            6'd13: u = mk(MS_FTAU,  ACT_ADD,  4'd0, 1'b0, 1'b0);
            6'd15: u = mk(MS_NONE,  ACT_NONE, 4'd0, 1'b1, 1'b0);
            // axis y
            6'd16: u = mk(MS_RG,    ACT_GRAV, 4'd1, 1'b0, 1'b0);
            6'd18: u = mk(MS_RESDT, ACT_SET,  4'd1, 1'b0, 1'b0);
            6'd19: u = mk(MS_FTAU,  ACT_ADD,  4'd1, 1'b0, 1'b0);
            6'd21: u = mk(MS_NONE,  ACT_NONE, 4'd1, 1'b1, 1'b0);
            // axis z
            6'd22: u = mk(MS_RG,    ACT_GRAV, 4'd2, 1'b0, 1'b0);
            6'd24: u = mk(MS_RESDT, ACT_SET,  4'd2, 1'b0, 1'b0);
            6'd25: u = mk(MS_FTAU,  ACT_ADD,  4'd2, 1'b0, 1'b0);
            6'd27: u = mk(MS_NONE,  ACT_NONE, 4'd2, 1'b1, 1'b0);
            // earth frame rows
            6'd28: u = mk(MS_RF, ACT_SET,   4'd0, 1'b0, 1'b0);
            6'd29: u = mk(MS_RF, ACT_ADD,   4'd1, 1'b0, 1'b0);
            6'd30: u = mk(MS_RF, ACT_EARTH, 4'd2, 1'b0, 1'b0);
            6'd31: u = mk(MS_RF, ACT_SET,   4'd3, 1'b0, 1'b0);
            6'd32: u = mk(MS_RF, ACT_ADD,   4'd4, 1'b0, 1'b0);
            6'd33: u = mk(MS_RF, ACT_EARTH, 4'd5, 1'b0, 1'b0);
            6'd34: u = mk(MS_RF, ACT_SET,   4'd6, 1'b0, 1'b0);
            6'd35: u = mk(MS_RF, ACT_ADD,   4'd7, 1'b0, 1'b0);
            6'd36: u = mk(MS_RF, ACT_EARTH, 4'd8, 1'b0, 1'b0);
            6'd38: u = mk(MS_NONE, ACT_NONE, 4'd0, 1'b0, 1'b1);
            default: u = mk(MS_NONE, ACT_NONE, 4'd0, 1'b0, 1'b0);
        endcase
        return u;
    endfunction

    function automatic logic signed [AW-1:0] sat19(logic signed [ACCW-1:0] v);
        logic signed [AW-1:0] r;
        if (v > ACCW'(OUT_MAX)) begin
            r = OUT_MAX;
        end else if (v < ACCW'(OUT_MIN)) begin
            r = OUT_MIN;
        end else begin
            r = v[AW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/gcma_datapath.sv =====
// datapath: operand muxes, shared multiplier, accumulator, divider and state
`timescale 1ns / 1ps

module gcma_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gcma_pkg::dp_cmd_t             cmd,
    output gcma_pkg::dp_status_t          status,
    input  logic                          cfg_we,
    input  logic [gcma_pkg::CFGIW-1:0]    cfg_index,
    input  logic [gcma_pkg::TAUW-1:0]     cfg_data,
    input  logic signed [gcma_pkg::QW-1:0] in_quat_w,
    input  logic signed [gcma_pkg::QW-1:0] in_quat_x,
    input  logic signed [gcma_pkg::QW-1:0] in_quat_y,
    input  logic signed [gcma_pkg::QW-1:0] in_quat_z,
    input  logic signed [gcma_pkg::AW-1:0] in_accel_x,
    input  logic signed [gcma_pkg::AW-1:0] in_accel_y,
    input  logic signed [gcma_pkg::AW-1:0] in_accel_z,
    input  logic [gcma_pkg::DTW-1:0]      in_elapsed_us,
    output logic signed [gcma_pkg::AW-1:0] out_body_x,
    output logic signed [gcma_pkg::AW-1:0] out_body_y,
    output logic signed [gcma_pkg::AW-1:0] out_body_z,
    output logic signed [gcma_pkg::AW-1:0] out_earth_x,
    output logic signed [gcma_pkg::AW-1:0] out_earth_y,
    output logic signed [gcma_pkg::AW-1:0] out_earth_z
);
    import gcma_pkg::*;

    logic [TAUW-1:0] tau_reg;
    logic [GW-1:0]   g_reg;

    logic signed [QW-1:0] q0_reg, q1_reg, q2_reg, q3_reg;
    logic signed [AW-1:0] ax_reg, ay_reg, az_reg;
    logic [DTW-1:0]       dt_reg;

    logic signed [PRODW-1:0] prod_reg [9];
    logic signed [RW-1:0]    r_mat [9];

    logic signed [OPAW-1:0] op_a;
    logic signed [OPBW-1:0] op_b;
    logic signed [MULW-1:0] mul_full;
    logic signed [MULW-1:0] mul_reg;
    act_t                   act_reg;
    logic [3:0]             aidx_reg;

    logic signed [RESW-1:0] res_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [AW-1:0]   f_reg [3];
    logic signed [AW-1:0]   earth_reg [3];

    logic signed [RW-1:0]   r_sel;
    logic signed [AW-1:0]   f_sel;
    logic signed [AW-1:0]   a_sel;
    logic signed [MULW-1:0] grav_rnd;
    logic signed [RESW-1:0] residue;
    logic signed [ACCW-1:0] mul_ext;
    logic signed [ACCW-1:0] earth_sum;
    logic signed [ACCW-1:0] earth_rnd;

    // divider
    logic                 busy_reg;
    logic [DCW-1:0]       cnt_reg;
    logic [MAGW-1:0]      dvd_reg;
    logic [DENW-1:0]      rem_reg;
    logic                 neg_reg;
    logic                 dz_reg;
    logic [1:0]           daxis_reg;
    logic [DENW-1:0]      den;
    logic signed [NUMW-1:0] num;
    logic [NUMW-1:0]      num_mag;
    logic [MAGW-1:0]      dvd_start;
    logic [DENW:0]        shifted;
    logic                 ge;
    logic [DENW:0]        diff;
    logic [MAGW-1:0]      quot;
    logic signed [ACCW-1:0] quot_s;
    logic                 div_done;

    assign den = DENW'(tau_reg) + DENW'(dt_reg);

    // rotation matrix from stored quaternion products
    always_comb begin
        r_mat[0] = (HALF_R - RW'(prod_reg[0]) - RW'(prod_reg[1])) <<< 1;
        r_mat[1] = (RW'(prod_reg[2]) - RW'(prod_reg[3])) <<< 1;
        r_mat[2] = (RW'(prod_reg[4]) + RW'(prod_reg[5])) <<< 1;
        r_mat[3] = (RW'(prod_reg[2]) + RW'(prod_reg[3])) <<< 1;
        r_mat[4] = (HALF_R - RW'(prod_reg[6]) - RW'(prod_reg[1])) <<< 1;
        r_mat[5] = (RW'(prod_reg[7]) - RW'(prod_reg[8])) <<< 1;
        r_mat[6] = (RW'(prod_reg[4]) - RW'(prod_reg[5])) <<< 1;
        r_mat[7] = (RW'(prod_reg[7]) + RW'(prod_reg[8])) <<< 1;
        r_mat[8] = (HALF_R - RW'(prod_reg[6]) - RW'(prod_reg[0])) <<< 1;
    end

    always_comb begin
        case (cmd.idx)
            4'd0:    r_sel = r_mat[0];
            4'd1:    r_sel = r_mat[1];
            4'd2:    r_sel = r_mat[2];
            4'd3:    r_sel = r_mat[3];
            4'd4:    r_sel = r_mat[4];
            4'd5:    r_sel = r_mat[5];
            4'd6:    r_sel = r_mat[6];
            4'd7:    r_sel = r_mat[7];
            4'd8:    r_sel = r_mat[8];
            default: r_sel = '0;
        endcase
    end

    // column of the current step for the earth rotation, axis otherwise
    always_comb begin
        if (cmd.msel == MS_RF) begin
            case (cmd.idx)
                4'd0, 4'd3, 4'd6: f_sel = f_reg[0];
                4'd1, 4'd4, 4'd7: f_sel = f_reg[1];
                default:          f_sel = f_reg[2];
            endcase
        end else begin
            case (cmd.idx)
                4'd0:    f_sel = f_reg[0];
                4'd1:    f_sel = f_reg[1];
                default: f_sel = f_reg[2];
            endcase
        end
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (cmd.msel)
            MS_QQ: begin
                case (cmd.idx)
                    4'd0:    begin op_a = OPAW'(q2_reg); op_b = OPBW'(q2_reg); end
                    4'd1:    begin op_a = OPAW'(q3_reg); op_b = OPBW'(q3_reg); end
                    4'd2:    begin op_a = OPAW'(q1_reg); op_b = OPBW'(q2_reg); end
                    4'd3:    begin op_a = OPAW'(q0_reg); op_b = OPBW'(q3_reg); end
                    4'd4:    begin op_a = OPAW'(q1_reg); op_b = OPBW'(q3_reg); end
                    4'd5:    begin op_a = OPAW'(q0_reg); op_b = OPBW'(q2_reg); end
                    4'd6:    begin op_a = OPAW'(q1_reg); op_b = OPBW'(q1_reg); end
                    4'd7:    begin op_a = OPAW'(q2_reg); op_b = OPBW'(q3_reg); end
                    default: begin op_a = OPAW'(q0_reg); op_b = OPBW'(q1_reg); end
                endcase
            end
            MS_RG: begin
                case (cmd.idx)
                    4'd0:    op_a = r_mat[6];
                    4'd1:    op_a = r_mat[7];
                    default: op_a = r_mat[8];
                endcase
                op_b = OPBW'(g_reg);
            end
            MS_RESDT: begin
                op_a = OPAW'(res_reg);
                op_b = OPBW'(dt_reg);
            end
            MS_FTAU: begin
                op_a = OPAW'(f_sel);
                op_b = OPBW'(tau_reg);
            end
            MS_RF: begin
                op_a = r_sel;
                op_b = OPBW'(f_sel);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_full = op_a * op_b;

    // actions on the registered product
    always_comb begin
        case (aidx_reg)
            4'd0:    a_sel = ax_reg;
            4'd1:    a_sel = ay_reg;
            default: a_sel = az_reg;
        endcase
    end

    assign grav_rnd  = (mul_reg + HALF_MUL) >>> FRAC;
    assign residue   = RESW'(a_sel) - grav_rnd[RESW-1:0];
    assign mul_ext   = ACCW'(mul_reg);
    assign earth_sum = acc_reg + mul_ext;
    assign earth_rnd = (earth_sum + HALF_ACC) >>> FRAC;

    // divider datapath, one quotient bit a cycle
    assign num       = acc_reg[NUMW-1:0];
    assign num_mag   = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    assign dvd_start = num_mag[MAGW-1:0] + MAGW'(den >> 1);
    assign shifted   = {rem_reg, dvd_reg[MAGW-1]};
    assign ge        = shifted >= {1'b0, den};
    assign diff      = shifted - {1'b0, den};
    assign quot      = {dvd_reg[MAGW-2:0], ge};
    assign quot_s    = neg_reg ? -ACCW'(quot) : ACCW'(quot);
    assign div_done  = busy_reg && (cnt_reg == DCW'(MAGW - 1));
    assign status.div_done = div_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tau_reg  <= TAU_RESET;
            g_reg    <= G_RESET;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            act_reg  <= ACT_NONE;
            aidx_reg <= '0;
            f_reg[0] <= '0;
            f_reg[1] <= '0;
            f_reg[2] <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_TAU) begin
                    tau_reg <= cfg_data;
                end else if (cfg_index == CFG_GRAV) begin
                    g_reg <= cfg_data[GW-1:0];
                end
            end
            act_reg  <= cmd.act;
            aidx_reg <= cmd.idx;
            if (cmd.div_start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (div_done) begin
                busy_reg <= 1'b0;
                if (!dz_reg) begin
                    f_reg[daxis_reg] <= sat19(quot_s);
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_full;
        if (cmd.load) begin
            q0_reg <= in_quat_w;
            q1_reg <= in_quat_x;
            q2_reg <= in_quat_y;
            q3_reg <= in_quat_z;
            ax_reg <= in_accel_x;
            ay_reg <= in_accel_y;
            az_reg <= in_accel_z;
            dt_reg <= in_elapsed_us;
        end
        case (act_reg)
            ACT_PROD:  prod_reg[aidx_reg] <= mul_reg[PRODW-1:0];
            ACT_GRAV:  res_reg <= residue;
            ACT_SET:   acc_reg <= mul_ext;
            ACT_ADD:   acc_reg <= earth_sum;
            ACT_EARTH: begin
                case (aidx_reg)
                    4'd2:    earth_reg[0] <= sat19(earth_rnd);
                    4'd5:    earth_reg[1] <= sat19(earth_rnd);
                    default: earth_reg[2] <= sat19(earth_rnd);
                endcase
            end
            default: ;
        endcase
        if (cmd.div_start) begin
            dvd_reg   <= dvd_start;
            rem_reg   <= '0;
            neg_reg   <= num[NUMW-1];
            dz_reg    <= (den == '0);
            daxis_reg <= cmd.idx[1:0];
        end else if (busy_reg) begin
            dvd_reg <= quot;
            rem_reg <= ge ? diff[DENW-1:0] : shifted[DENW-1:0];
        end
        if (cmd.out_load) begin
            out_body_x  <= f_reg[0];
            out_body_y  <= f_reg[1];
            out_body_z  <= f_reg[2];
            out_earth_x <= earth_reg[0];
            out_earth_y <= earth_reg[1];
            out_earth_z <= earth_reg[2];
        end
    end

endmodule

// ===== hw/rtl/gcma_ctrl.sv =====
// controller: step sequencer, divider wait and output handshake
`timescale 1ns / 1ps

module gcma_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output gcma_pkg::dp_cmd_t    cmd,
    input  gcma_pkg::dp_status_t status
);
    import gcma_pkg::*;

    state_t            state_reg, state_next;
    logic [STEPW-1:0]  step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    ucode_t            uc;

    assign uc      = ucode(step_reg);
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (uc.last) begin
                    // wait for the output register to free up
                    if (!m_valid_reg || m_ready) begin
                        cmd.out_load = 1'b1;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else if (uc.div) begin
                    cmd.div_start = 1'b1;
                    cmd.idx       = uc.idx;
                    state_next    = ST_DIV;
                end else begin
                    cmd.msel  = uc.msel;
                    cmd.act   = uc.act;
                    cmd.idx   = uc.idx;
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/gravity_compensated_motion_accel.sv =====
// gravity-compensated motion acceleration, top level
//
// input beat: attitude quaternion (Q2.14), body accelerometer sample and
// elapsed time. gravity is rotated into the body frame, subtracted, and the
// residue goes through a first-order low-pass per axis; one output beat
// carries the filtered body vector and its earth-frame rotation.
// from accept to output valid, one item runs 39 sequencer steps on
// a single shared 34x22 multiplier, plus three 41-bit restoring
// divisions (one quotient bit a cycle) for the filter update.
// one item is in flight at a time; s_ready is high only while idle, so
// the next beat can be taken from the cycle in which output valid rises.
// the result sits in an output register, so a new beat can be accepted
// while the last result waits; if m_ready stays low, the next result
// holds at its final step until the register frees up.
// configuration writes (cfg_index 0: tau in us, 1: gravity) are always
// taken and must only be issued while idle; other indexes are ignored.
// reset loads default tau and gravity and clears the filter state.
`timescale 1ns / 1ps

module gravity_compensated_motion_accel (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gcma_pkg::CFGIW-1:0]     cfg_index,
    input  logic [gcma_pkg::TAUW-1:0]      cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [gcma_pkg::QW-1:0] s_quat_w,
    input  logic signed [gcma_pkg::QW-1:0] s_quat_x,
    input  logic signed [gcma_pkg::QW-1:0] s_quat_y,
    input  logic signed [gcma_pkg::QW-1:0] s_quat_z,
    input  logic signed [gcma_pkg::AW-1:0] s_accel_x,
    input  logic signed [gcma_pkg::AW-1:0] s_accel_y,
    input  logic signed [gcma_pkg::AW-1:0] s_accel_z,
    input  logic [gcma_pkg::DTW-1:0]       s_elapsed_us,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [gcma_pkg::AW-1:0] m_motion_body_x,
    output logic signed [gcma_pkg::AW-1:0] m_motion_body_y,
    output logic signed [gcma_pkg::AW-1:0] m_motion_body_z,
    output logic signed [gcma_pkg::AW-1:0] m_motion_earth_x,
    output logic signed [gcma_pkg::AW-1:0] m_motion_earth_y,
    output logic signed [gcma_pkg::AW-1:0] m_motion_earth_z
);
    import gcma_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    gcma_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    gcma_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_quat_w     (s_quat_w),
        .in_quat_x     (s_quat_x),
        .in_quat_y     (s_quat_y),
        .in_quat_z     (s_quat_z),
        .in_accel_x    (s_accel_x),
        .in_accel_y    (s_accel_y),
        .in_accel_z    (s_accel_z),
        .in_elapsed_us (s_elapsed_us),
        .out_body_x    (m_motion_body_x),
        .out_body_y    (m_motion_body_y),
        .out_body_z    (m_motion_body_z),
        .out_earth_x   (m_motion_earth_x),
        .out_earth_y   (m_motion_earth_y),
        .out_earth_z   (m_motion_earth_z)
    );

    // busy right after an input beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready high right after input beat");

    // a division never finishes while the block claims to be idle
    a_div_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> !s_ready)
        else $error("divider done while idle");

    // the output register is never overwritten while its beat is pending
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output overwritten while pending");

    // neither a new result nor a new input is loaded together with a divider start
    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !cmd.out_load && !cmd.load)
        else $error("conflicting datapath commands");

endmodule

// ===== test/gravity_compensated_motion_accel_test.sv =====
// testbench for the gravity-compensated motion acceleration block
`timescale 1ns / 1ps

module gravity_compensated_motion_accel_test;
    import gcma_pkg::*;

    localparam logic [CFGIW-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFGIW-1:0] CFG_SPARE_3 = 2'd3;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct {
        logic signed [QW-1:0] qw, qx, qy, qz;
        logic signed [AW-1:0] ax, ay, az;
        logic [DTW-1:0]       dt;
    } imu_sample_t;

    typedef struct {
        logic signed [AW-1:0] bx, by, bz, ex, ey, ez;
    } motion_t;

    logic aclk;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFGIW-1:0] cfg_index;
    logic [TAUW-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic signed [QW-1:0] s_quat_w, s_quat_x, s_quat_y, s_quat_z;
    logic signed [AW-1:0] s_accel_x, s_accel_y, s_accel_z;
    logic [DTW-1:0] s_elapsed_us;
    logic m_valid;
    logic m_ready;
    logic signed [AW-1:0] m_motion_body_x, m_motion_body_y, m_motion_body_z;
    logic signed [AW-1:0] m_motion_earth_x, m_motion_earth_y, m_motion_earth_z;

    gravity_compensated_motion_accel u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_quat_w(s_quat_w), .s_quat_x(s_quat_x),
        .s_quat_y(s_quat_y), .s_quat_z(s_quat_z),
        .s_accel_x(s_accel_x), .s_accel_y(s_accel_y), .s_accel_z(s_accel_z),
        .s_elapsed_us(s_elapsed_us),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_motion_body_x(m_motion_body_x), .m_motion_body_y(m_motion_body_y),
        .m_motion_body_z(m_motion_body_z), .m_motion_earth_x(m_motion_earth_x),
        .m_motion_earth_y(m_motion_earth_y), .m_motion_earth_z(m_motion_earth_z)
    );

    // shadow of the block's registers and filter state
    longint tau_us;
    longint grav_mag;
    longint lp_state [3];

    motion_t expected_motion [$];
    int      error_count;
    int      sample_count;
    int      result_count;
    int      cycle_count;
    bit      no_idle;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint sat_field(longint v);
        if (v > 262143) begin
            return 262143;
        end
        if (v < -262144) begin
            return -262144;
        end
        return v;
    endfunction

    function automatic longint div_nearest(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // rotation, gravity removal, low-pass and earth-frame rotation
    function automatic motion_t filter_motion(imu_sample_t s);
        longint q0, q1, q2, q3, dt, den, grav_b, residue, e;
        longint acc [3];
        longint rot [3][3];
        longint earth [3];
        motion_t m;
        q0 = longint'(s.qw); q1 = longint'(s.qx);
        q2 = longint'(s.qy); q3 = longint'(s.qz);
        acc[0] = longint'(s.ax); acc[1] = longint'(s.ay); acc[2] = longint'(s.az);
        dt = longint'(s.dt);
        den = tau_us + dt;
        rot[0][0] = 2 * (134217728 - q2 * q2 - q3 * q3);
        rot[0][1] = 2 * (q1 * q2 - q0 * q3);
        rot[0][2] = 2 * (q1 * q3 + q0 * q2);
        rot[1][0] = 2 * (q1 * q2 + q0 * q3);
        rot[1][1] = 2 * (134217728 - q1 * q1 - q3 * q3);
        rot[1][2] = 2 * (q2 * q3 - q0 * q1);
        rot[2][0] = 2 * (q1 * q3 - q0 * q2);
        rot[2][1] = 2 * (q2 * q3 + q0 * q1);
        rot[2][2] = 2 * (134217728 - q1 * q1 - q2 * q2);
        for (int i = 0; i < 3; i++) begin
            // half-up rounding of a Q28 value is a floor after adding one half
            grav_b = (rot[2][i] * grav_mag + 134217728) >>> 28;
            residue = acc[i] - grav_b;
            if (den > 0) begin
                lp_state[i] = sat_field(div_nearest(residue * dt + lp_state[i] * tau_us, den));
            end
        end
        for (int i = 0; i < 3; i++) begin
            e = rot[i][0] * lp_state[0] + rot[i][1] * lp_state[1] + rot[i][2] * lp_state[2];
            earth[i] = sat_field((e + 134217728) >>> 28);
        end
        m.bx = AW'(lp_state[0]); m.by = AW'(lp_state[1]); m.bz = AW'(lp_state[2]);
        m.ex = AW'(earth[0]);    m.ey = AW'(earth[1]);    m.ez = AW'(earth[2]);
        return m;
    endfunction

    task automatic send_sample(imu_sample_t s);
        int gap;
        gap = no_idle ? 0 : $urandom_range(13);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end else begin
            @(negedge aclk);
        end
        s_quat_w <= s.qw; s_quat_x <= s.qx; s_quat_y <= s.qy; s_quat_z <= s.qz;
        s_accel_x <= s.ax; s_accel_y <= s.ay; s_accel_z <= s.az;
        s_elapsed_us <= s.dt;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_motion.push_back(filter_motion(s));
        sample_count++;
    endtask

    // waits for the block to go idle before touching its registers
    task automatic drain;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_motion.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFGIW-1:0] idx, logic [TAUW-1:0] data);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_TAU) begin
            tau_us = longint'(data);
        end else if (idx == CFG_GRAV) begin
            grav_mag = longint'(data[GW-1:0]);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic imu_sample_t mk_sample(int w, int x, int y, int z,
                                              int ax, int ay, int az, int dt);
        imu_sample_t s;
        s.qw = QW'(w); s.qx = QW'(x); s.qy = QW'(y); s.qz = QW'(z);
        s.ax = AW'(ax); s.ay = AW'(ay); s.az = AW'(az); s.dt = DTW'(dt);
        return s;
    endfunction

    function automatic imu_sample_t random_sample();
        imu_sample_t s;
        real a, b, c, d, n;
        int pick;
        pick = $urandom_range(99);
        a = $itor($signed($urandom_range(32768)) - 16384);
        b = $itor($signed($urandom_range(32768)) - 16384);
        c = $itor($signed($urandom_range(32768)) - 16384);
        d = $itor($signed($urandom_range(32768)) - 16384);
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (pick < 75 && n > 1.0) begin
            // unit attitude with random direction
            s.qw = QW'($rtoi(a * 16384.0 / n)); s.qx = QW'($rtoi(b * 16384.0 / n));
            s.qy = QW'($rtoi(c * 16384.0 / n)); s.qz = QW'($rtoi(d * 16384.0 / n));
        end else begin
            s.qw = QW'($rtoi(a)); s.qx = QW'($rtoi(b));
            s.qy = QW'($rtoi(c)); s.qz = QW'($rtoi(d));
        end
        if ($urandom_range(9) < 7) begin
            s.ax = AW'($signed($urandom_range(40000)) - 20000);
            s.ay = AW'($signed($urandom_range(40000)) - 20000);
            s.az = AW'($signed($urandom_range(40000)) - 20000 + 10037);
        end else begin
            s.ax = AW'($urandom); s.ay = AW'($urandom); s.az = AW'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
            s.dt = DTW'($urandom_range(2000, 500));
        end else if (pick < 97) begin
            s.dt = DTW'($urandom_range(65535, 1));
        end else begin
            s.dt = '0;
        end
        return s;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            send_sample(random_sample());
        end
    endtask

    task automatic test_directed_extremes;
        send_sample(mk_sample(16384, 0, 0, 0, 0, 0, 10037, 1000));
        send_sample(mk_sample(16384, 0, 0, 0, 262143, 262143, 262143, 65535));
        send_sample(mk_sample(16384, 0, 0, 0, -262144, -262144, -262144, 65535));
        send_sample(mk_sample(-16384, 0, 0, 0, 1000, -1000, 5000, 1));
        send_sample(mk_sample(0, 16384, 0, 0, 0, 0, -10037, 1000));
        send_sample(mk_sample(0, 0, -16384, 0, 300, 200, 100, 2000));
        send_sample(mk_sample(0, 0, 0, 16384, -300, 0, 10037, 500));
        send_sample(mk_sample(11585, 11585, 0, 0, 7000, -7000, 7000, 1000));
        send_sample(mk_sample(8192, -8192, 8192, -8192, 1, -1, 0, 750));
        // unnormalized attitudes with extreme acceleration samples
        send_sample(mk_sample(16384, 16384, 16384, 16384, 262143, -262144, 262143, 65535));
        send_sample(mk_sample(-16384, -16384, -16384, -16384, -262144, 262143, 0, 65535));
        send_sample(mk_sample(0, 0, 0, 0, 123, 456, -789, 1000));
        // zero elapsed time holds the state
        send_sample(mk_sample(16384, 0, 0, 0, 99999, 99999, 99999, 0));
        send_sample(mk_sample(0, 16384, 16384, 0, -5, 5, -5, 0));
        send_sample(mk_sample(16384, 0, 0, 0, 0, 0, 0, 1));
        send_sample(mk_sample(-1, -1, -1, -1, -1, -1, -1, 65535));
    endtask

    task automatic test_register_extremes;
        drain();
        write_reg(CFG_TAU, 20'd0);
        write_reg(CFG_GRAV, 20'd0);
        // zero time constant: the state follows the residue
        send_sample(mk_sample(16384, 0, 0, 0, 262143, -262144, 42, 1000));
        send_sample(mk_sample(0, 16384, 0, 0, -3, 7, 11, 1));
        // zero time constant and zero elapsed time: state held
        send_sample(mk_sample(0, 0, 16384, 0, 50000, 50000, 50000, 0));
        run_random(60);
        drain();
        write_reg(CFG_TAU, 20'd1000000);
        write_reg(CFG_GRAV, 20'd16384);
        send_sample(mk_sample(16384, 0, 0, 0, 262143, 262143, 262143, 65535));
        run_random(80);
        drain();
        // only the low bits reach the gravity register; spare indexes do nothing
        write_reg(CFG_GRAV, 20'hFFFFF);
        write_reg(CFG_SPARE_2, 20'd7);
        write_reg(CFG_SPARE_3, 20'hABCDE);
        write_reg(CFG_TAU, 20'hFFFFF);
        run_random(60);
    endtask

    task automatic test_random_settings;
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            write_reg(CFG_TAU, (phase % 2) ? TAUW'($urandom_range(20000))
                                           : TAUW'($urandom_range(1000000)));
            write_reg(CFG_GRAV, (phase == 5) ? 20'd10037 : TAUW'($urandom_range(16384)));
            no_idle = (phase == 2);
            run_random(150);
        end
        no_idle = 1'b0;
    endtask

    // result side stall, drawn per beat
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(13);
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        motion_t exp_m;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (expected_motion.size() == 0) begin
                $display("%0t: unexpected result beat", $time);
                error_count++;
            end else begin
                exp_m = expected_motion.pop_front();
                if (m_motion_body_x !== exp_m.bx || m_motion_body_y !== exp_m.by ||
                    m_motion_body_z !== exp_m.bz || m_motion_earth_x !== exp_m.ex ||
                    m_motion_earth_y !== exp_m.ey || m_motion_earth_z !== exp_m.ez) begin
                    $display("%0t: mismatch expected body %0d %0d %0d earth %0d %0d %0d",
                             $time, exp_m.bx, exp_m.by, exp_m.bz,
                             exp_m.ex, exp_m.ey, exp_m.ez);
                    $display("%0t:          actual   body %0d %0d %0d earth %0d %0d %0d",
                             $time, m_motion_body_x, m_motion_body_y, m_motion_body_z,
                             m_motion_earth_x, m_motion_earth_y, m_motion_earth_z);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timed out, %0d results outstanding", $time, expected_motion.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        s_valid = 1'b0;
        s_quat_w = '0; s_quat_x = '0; s_quat_y = '0; s_quat_z = '0;
        s_accel_x = '0; s_accel_y = '0; s_accel_z = '0; s_elapsed_us = '0;
        tau_us = longint'(TAU_RESET);
        grav_mag = longint'(G_RESET);
        for (int i = 0; i < 3; i++) lp_state[i] = 0;
        error_count = 0; sample_count = 0; result_count = 0; cycle_count = 0;
        no_idle = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_extremes();
        test_register_extremes();
        test_random_settings();
        drain();

        $display("covered %0d samples and %0d result beats over tau and gravity settings",
                 sample_count, result_count);
        $display("including zero, maximum and out-of-list register writes");
        if (error_count == 0 && expected_motion.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== gravity_compensated_motion_accel.f =====
hw/rtl/gcma_pkg.sv
hw/rtl/gcma_datapath.sv
hw/rtl/gcma_ctrl.sv
hw/rtl/gravity_compensated_motion_accel.sv
test/gravity_compensated_motion_accel_test.sv
